/* rtl/bqlpf_pkg.sv */
// ----------------------------------------------------------------------------
// bqlpf_pkg
// Shared codes and fixed field widths for the multichannel biquad low-pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bqlpf_pkg;

  // fixed field widths
  localparam int CHANNEL_W = 3;
  localparam int REG_IDX_W = 2;

  // item operation codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_COEF_B   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FB1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FB2 = 2'd2;

  // mid tap gain of the feedforward section, applied as a shift
  localparam int TAP_MID_SHIFT = 1;

endpackage

`default_nettype wire

/* rtl/multichannel_butterworth_biquad_lpf.sv */
// An accepted item waits in the input register and moves on into the result register,
// which raises out_valid, as soon as the result register is empty or drains.
// Throughput: one item per clock while out_ready is not held low; the history read, five multiplies, the sum,
// rounding and saturation all sit in the single stage before the result register.
// Reset (rst, synchronous): clears coefficients, all channel histories and
// both stage valid flags.
// ----------------------------------------------------------------------------
// multichannel_butterworth_biquad_lpf
// Direct-form-I second-order low-pass shared by several channels, with
// per-channel history, rounding to nearest and output saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multichannel_butterworth_biquad_lpf #(
  parameter int CHANNELS       = 8,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 op,
  input  wire logic [bqlpf_pkg::CHANNEL_W-1:0]      channel,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]             filtered,
  output logic [bqlpf_pkg::CHANNEL_W-1:0]           out_channel,
  output logic                                      clipped,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [bqlpf_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [COEF_FRAC_BITS+1:0]            cfg_data
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W     = PROD_W + 3;
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_VALUES = 1 << bqlpf_pkg::CHANNEL_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // channel field to history slot, channel modulo CHANNELS as a small table
  function automatic logic [IDX_W-1:0] slot_of(input logic [bqlpf_pkg::CHANNEL_W-1:0] c);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < CH_VALUES; i++) begin
      if (c == bqlpf_pkg::CHANNEL_W'(i)) r = IDX_W'(i % CHANNELS);
    end
    return r;
  endfunction

  // coefficient registers
  logic signed [COEF_BITS-1:0] coef_b;
  logic signed [COEF_BITS-1:0] coef_fb1;
  logic signed [COEF_BITS-1:0] coef_fb2;

  // per-channel history
  logic signed [SAMPLE_BITS-1:0] in_hist1  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] in_hist2  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_hist1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_hist2 [CHANNELS];

  // input register
  logic                                stage_valid;
  logic                                stage_op;
  logic [bqlpf_pkg::CHANNEL_W-1:0]     stage_channel;
  logic signed [SAMPLE_BITS-1:0]       stage_sample;

  logic                                advance;
  logic                                stage_fire;
  logic [IDX_W-1:0]                    slot;
  logic signed [SAMPLE_BITS-1:0]       x1;
  logic signed [SAMPLE_BITS-1:0]       x2;
  logic signed [SAMPLE_BITS-1:0]       y1;
  logic signed [SAMPLE_BITS-1:0]       y2;
  logic signed [SAMPLE_BITS:0]         x1_dbl;
  logic signed [PROD_W-1:0]            t_x0;
  logic signed [PROD_W:0]              t_x1;
  logic signed [PROD_W-1:0]            t_x2;
  logic signed [PROD_W-1:0]            t_y1;
  logic signed [PROD_W-1:0]            t_y2;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             acc_shr;
  logic signed [SAMPLE_BITS-1:0]       y_next;
  logic                                clip_next;

  // handshake: result register empties or drains, input register follows
  assign advance    = !out_valid || out_ready;
  assign stage_fire = stage_valid && advance;
  assign in_ready   = !stage_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b   <= '0;
      coef_fb1 <= '0;
      coef_fb2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqlpf_pkg::REG_COEF_B:   coef_b   <= cfg_data;
        bqlpf_pkg::REG_COEF_FB1: coef_fb1 <= cfg_data;
        bqlpf_pkg::REG_COEF_FB2: coef_fb2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_op      <= op;
      stage_channel <= channel;
      stage_sample  <= sample;
    end
  end

  // history read for the staged item
  assign slot   = slot_of(stage_channel);
  assign x1     = in_hist1[slot];
  assign x2     = in_hist2[slot];
  assign y1     = out_hist1[slot];
  assign y2     = out_hist2[slot];
  assign x1_dbl = $signed({x1, 1'b0});

  // tap products and sum
  always_comb begin
    t_x0    = coef_b * stage_sample;
    t_x1    = coef_b * x1_dbl;
    t_x2    = coef_b * x2;
    t_y1    = coef_fb1 * y1;
    t_y2    = coef_fb2 * y2;
    acc     = ACC_W'(t_x0) + ACC_W'(t_x1) + ACC_W'(t_x2) + ACC_W'(t_y1) + ACC_W'(t_y2);
    acc_shr = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
  end

  // saturation, clear forces zero
  always_comb begin
    y_next    = SAMPLE_BITS'(acc_shr);
    clip_next = 1'b0;
    if (stage_op == bqlpf_pkg::OP_CLEAR) begin
      y_next = '0;
    end else if (acc_shr > SAT_HI) begin
      y_next    = SAMPLE_BITS'(SAT_HI);
      clip_next = 1'b1;
    end else if (acc_shr < SAT_LO) begin
      y_next    = SAMPLE_BITS'(SAT_LO);
      clip_next = 1'b1;
    end
  end

  // history update as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        in_hist1[i]  <= '0;
        in_hist2[i]  <= '0;
        out_hist1[i] <= '0;
        out_hist2[i] <= '0;
      end
    end else if (stage_fire) begin
      if (stage_op == bqlpf_pkg::OP_CLEAR) begin
        in_hist1[slot]  <= '0;
        in_hist2[slot]  <= '0;
        out_hist1[slot] <= '0;
        out_hist2[slot] <= '0;
      end else begin
        in_hist1[slot]  <= stage_sample;
        in_hist2[slot]  <= x1;
        out_hist1[slot] <= y_next;
        out_hist2[slot] <= y1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      filtered    <= y_next;
      out_channel <= stage_channel;
      clipped     <= clip_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bqlpf_checker.sv */
// ----------------------------------------------------------------------------
// bqlpf_checker
// Port-level checks on the multichannel biquad low-pass, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqlpf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [SAMPLE_BITS-1:0]    filtered,
  input wire logic [bqlpf_pkg::CHANNEL_W-1:0]  out_channel,
  input wire logic                             clipped
);

  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (filtered == OUT_MAX || filtered == OUT_MIN))
    else $error("clipped result not at a saturation limit");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(filtered) && $stable(out_channel) && $stable(clipped)))
    else $error("stalled result changed");

endmodule

bind multichannel_butterworth_biquad_lpf bqlpf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bqlpf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .filtered   (filtered),
  .out_channel(out_channel),
  .clipped    (clipped)
);

`default_nettype wire

/* tb/tb_multichannel_butterworth_biquad_lpf.sv */
// ----------------------------------------------------------------------------
// tb_multichannel_butterworth_biquad_lpf
// Self-checking bench for the multichannel biquad low-pass. A bit-exact
// predictor keeps its own per-channel history and coefficient copies and
// computes every result when the input item is taken. Directed tests cover
// reset coefficients, saturation at both rails, round-half-up and channel
// clear. Random phases then run under several coefficient sets, extremes
// included, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_butterworth_biquad_lpf;

  localparam int CHANNELS       = 8;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int     COEF_MAX   = (1 << (COEF_BITS - 1)) - 1;
  localparam int     COEF_MIN   = -(1 << (COEF_BITS - 1));

  // index with no register behind it, writes there must change nothing
  localparam logic [bqlpf_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // butterworth sets in Q2.16, cutoff near fs/10 and fs/50
  localparam int BW10_B   = 4424;
  localparam int BW10_FB1 = 74907;
  localparam int BW10_FB2 = -27054;
  localparam int BW50_B   = 237;
  localparam int BW50_FB1 = 119456;
  localparam int BW50_FB2 = -54867;

  // cycles with no item moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]     filtered;
    logic [bqlpf_pkg::CHANNEL_W-1:0]   chan;
    logic                              clip;
  } lpf_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              op = bqlpf_pkg::OP_FILTER;
  logic [bqlpf_pkg::CHANNEL_W-1:0]   channel = '0;
  logic signed [SAMPLE_BITS-1:0]     sample = '0;

  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0]     filtered;
  logic [bqlpf_pkg::CHANNEL_W-1:0]   out_channel;
  logic                              clipped;

  logic                              cfg_we = 1'b0;
  logic [bqlpf_pkg::REG_IDX_W-1:0]   cfg_index = '0;
  logic [COEF_BITS-1:0]              cfg_data = '0;

  // predictor state
  longint gain_b, gain_fb1, gain_fb2;
  longint xh1 [CHANNELS];
  longint xh2 [CHANNELS];
  longint yh1 [CHANNELS];
  longint yh2 [CHANNELS];

  lpf_result_t filter_results_due[$];

  bit steady_flow = 1'b0;
  int err_count = 0;
  int items_in = 0;
  int clears_in = 0;
  int results_out = 0;
  int clipped_out = 0;
  int coef_sets = 0;
  int idle_cycles = 0;

  multichannel_butterworth_biquad_lpf #(
    .CHANNELS      (CHANNELS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .filtered   (filtered),
    .out_channel(out_channel),
    .clipped    (clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void lpf_clear_all();
    gain_b   = 0;
    gain_fb1 = 0;
    gain_fb2 = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      xh1[i] = 0;
      xh2[i] = 0;
      yh1[i] = 0;
      yh2[i] = 0;
    end
  endfunction

  // one item through the filter, history updated in place
  function automatic lpf_result_t lpf_predict(input logic op_i,
                                              input logic [bqlpf_pkg::CHANNEL_W-1:0] ch_i,
                                              input logic signed [SAMPLE_BITS-1:0] x_i);
    lpf_result_t r;
    longint xv;
    longint acc;
    longint y;
    int idx;
    idx = ch_i % CHANNELS;
    xv = x_i;
    r.chan = ch_i;
    r.filtered = '0;
    r.clip = 1'b0;
    if (op_i == bqlpf_pkg::OP_CLEAR) begin
      xh1[idx] = 0;
      xh2[idx] = 0;
      yh1[idx] = 0;
      yh2[idx] = 0;
    end else begin
      acc = gain_b * xv + 2 * gain_b * xh1[idx] + gain_b * xh2[idx]
          + gain_fb1 * yh1[idx] + gain_fb2 * yh2[idx];
      // arithmetic shift is a floor, so this rounds half toward plus infinity
      y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        r.clip = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        r.clip = 1'b1;
      end
      xh2[idx] = xh1[idx];
      xh1[idx] = xv;
      yh2[idx] = yh1[idx];
      yh1[idx] = y;
      r.filtered = y[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, accepted items and result checks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lpf_result_t want;
    if (rst) begin
      lpf_clear_all();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          bqlpf_pkg::REG_COEF_B:   gain_b   = $signed(cfg_data);
          bqlpf_pkg::REG_COEF_FB1: gain_fb1 = $signed(cfg_data);
          bqlpf_pkg::REG_COEF_FB2: gain_fb2 = $signed(cfg_data);
          default: ;
        endcase
      end
      // accepted input item
      if (in_valid && in_ready) begin
        filter_results_due.push_back(lpf_predict(op, channel, sample));
        items_in++;
        if (op == bqlpf_pkg::OP_CLEAR) clears_in++;
      end
      // accepted result item
      if (out_valid && out_ready) begin
        results_out++;
        if (clipped) clipped_out++;
        if (filter_results_due.size() == 0) begin
          $error("result with nothing expected: filtered %0d channel %0d clipped %0b",
                 filtered, out_channel, clipped);
          err_count++;
        end else begin
          want = filter_results_due.pop_front();
          if (filtered !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
            err_count++;
          end
          if (out_channel !== want.chan) begin
            $error("out_channel: expected %0d, actual %0d", want.chan, out_channel);
            err_count++;
          end
          if (clipped !== want.clip) begin
            $error("clipped: expected %0b, actual %0b", want.clip, clipped);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each result
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ---------------------------------------------------------------------------
  // shared tasks
  // ---------------------------------------------------------------------------

  // one input item, with a random gap in front of it
  task automatic send_item(input logic op_i, input logic [bqlpf_pkg::CHANNEL_W-1:0] ch_i,
                           input logic signed [SAMPLE_BITS-1:0] x_i);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_i;
    channel  <= ch_i;
    sample   <= x_i;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (filter_results_due.size() != 0);
  endtask

  // write all three coefficients, optionally poke the unused index too
  task automatic load_coefs(input int b, input int fb1, input int fb2,
                            input bit touch_unused);
    cfg_we    <= 1'b1;
    cfg_index <= bqlpf_pkg::REG_COEF_B;
    cfg_data  <= b[COEF_BITS-1:0];
    @(posedge clk);
    cfg_index <= bqlpf_pkg::REG_COEF_FB1;
    cfg_data  <= fb1[COEF_BITS-1:0];
    @(posedge clk);
    cfg_index <= bqlpf_pkg::REG_COEF_FB2;
    cfg_data  <= fb2[COEF_BITS-1:0];
    @(posedge clk);
    if (touch_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= COEF_BITS'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_BITS'(SAMPLE_MAX);
      1: return SAMPLE_BITS'(SAMPLE_MIN);
      2: return SAMPLE_BITS'($urandom_range(0, 128) - 64);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_coef();
    return $urandom_range(0, (1 << COEF_BITS) - 1) + COEF_MIN;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // coefficients are zero out of reset, so every output is zero
  task automatic test_reset_coefs();
    send_item(bqlpf_pkg::OP_FILTER, 3'd0, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_FILTER, 3'd7, SAMPLE_BITS'(SAMPLE_MIN));
    settle();
  endtask

  // full-scale gain drives both rails
  task automatic test_saturation();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
    send_item(bqlpf_pkg::OP_FILTER, 3'd1, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_FILTER, 3'd1, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_FILTER, 3'd1, SAMPLE_BITS'(SAMPLE_MIN));
    settle();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
    send_item(bqlpf_pkg::OP_FILTER, 3'd2, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_FILTER, 3'd2, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_FILTER, 3'd2, SAMPLE_BITS'(SAMPLE_MIN));
    settle();
  endtask

  // b = 0.5 puts +-1 inputs exactly on the rounding tie; unused index poked
  task automatic test_rounding();
    load_coefs(1 << (COEF_FRAC_BITS - 1), 0, 0, 1'b1);
    send_item(bqlpf_pkg::OP_FILTER, 3'd4, SAMPLE_BITS'(1));
    send_item(bqlpf_pkg::OP_FILTER, 3'd5, SAMPLE_BITS'(-1));
    send_item(bqlpf_pkg::OP_FILTER, 3'd6, SAMPLE_BITS'(3));
    send_item(bqlpf_pkg::OP_FILTER, 3'd6, SAMPLE_BITS'(-3));
    settle();
  endtask

  // clear wipes one channel only and ignores its sample
  task automatic test_clear();
    load_coefs(BW10_B, BW10_FB1, BW10_FB2, 1'b0);
    send_item(bqlpf_pkg::OP_FILTER, 3'd7, SAMPLE_BITS'(20000));
    send_item(bqlpf_pkg::OP_FILTER, 3'd0, SAMPLE_BITS'(-20000));
    send_item(bqlpf_pkg::OP_FILTER, 3'd7, SAMPLE_BITS'(20000));
    send_item(bqlpf_pkg::OP_CLEAR,  3'd7, SAMPLE_BITS'(SAMPLE_MIN));
    send_item(bqlpf_pkg::OP_FILTER, 3'd7, SAMPLE_BITS'(0));
    send_item(bqlpf_pkg::OP_FILTER, 3'd0, SAMPLE_BITS'(0));
    send_item(bqlpf_pkg::OP_CLEAR,  3'd0, SAMPLE_BITS'(SAMPLE_MAX));
    send_item(bqlpf_pkg::OP_CLEAR,  3'd0, SAMPLE_BITS'(0));
    settle();
  endtask

  // one coefficient set, random items, flow mode redrawn every 40 items
  task automatic run_phase(input int b, input int fb1, input int fb2, input int n);
    load_coefs(b, fb1, fb2, $urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_item(($urandom_range(0, 19) == 0) ? bqlpf_pkg::OP_CLEAR : bqlpf_pkg::OP_FILTER,
                bqlpf_pkg::CHANNEL_W'($urandom_range(0, 7)), pick_sample());
    end
    steady_flow = 1'b0;
    settle();
  endtask

  task automatic test_random();
    run_phase(BW10_B, BW10_FB1, BW10_FB2, 200);
    run_phase(pick_coef(), pick_coef(), pick_coef(), 200);
    run_phase(COEF_MAX, COEF_MAX, COEF_MAX, 200);
    run_phase(COEF_MIN, COEF_MIN, COEF_MIN, 200);
    run_phase(BW50_B, BW50_FB1, BW50_FB2, 200);
    run_phase(COEF_MAX, 0, 0, 200);
    run_phase(pick_coef(), pick_coef(), pick_coef(), 200);
    run_phase(COEF_MIN, COEF_MAX, COEF_MIN, 200);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_coefs();
    test_saturation();
    test_rounding();
    test_clear();
    test_random();
    settle();
    repeat (4) @(posedge clk);
    $display("run covered %0d items (%0d clears) under %0d coefficient sets",
             items_in, clears_in, coef_sets);
    $display("%0d results checked, %0d of them saturated, %0d mismatches",
             results_out, clipped_out, err_count);
    if (err_count == 0 && filter_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
